### rtl/core/sorted_array_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_macros
// Assertion macros for the priority queue; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define SPAQ_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPAQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SPAQ_ASSERT_ALWAYS(label, expr, msg)
`define SPAQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/spaq_pkg.sv
// ----------------------------------------------------------------------------
// spaq_pkg
// Types and constants shared by the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spaq_pkg;

   localparam int DATA_W     = 32;
   localparam int FIELD_PRIO = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CAP_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // register index taken from the word address bit
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                  req_type;
      logic signed [DATA_W-1:0] item_data;
      logic [FIELD_PRIO-1:0] item_priority;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] popped_data;
      logic [FIELD_PRIO-1:0]    popped_priority;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_payload_type;

   // operation broadcast to every cell of the chain
   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctrl_type;

endpackage

### rtl/core/spaq_cell.sv
// ----------------------------------------------------------------------------
// spaq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes its neighbor's entry so the chain stays sorted.
// ----------------------------------------------------------------------------
module spaq_cell
   import spaq_pkg::*;
#(
   parameter int PRIO_BITS = 8,
   parameter int CNT_BITS  = 5,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [CNT_BITS-1:0]  count,
   input  logic [DATA_W-1:0]    new_data,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [DATA_W-1:0]    prev_data,
   input  logic [PRIO_BITS-1:0] prev_prio,
   input  logic                 prev_stay,
   input  logic [DATA_W-1:0]    next_data,
   input  logic [PRIO_BITS-1:0] next_prio,
   output logic [DATA_W-1:0]    data,
   output logic [PRIO_BITS-1:0] prio,
   output logic                 stay
);

   logic [DATA_W-1:0]    data_ff, data_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 occupied;

   assign occupied = count > CNT_BITS'(INDEX);
   // equal priority stays ahead of the new entry
   assign stay     = occupied && (prio_ff >= new_prio);
   assign data     = data_ff;
   assign prio     = prio_ff;

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctrl.ins) begin
         if (!stay) begin
            if (prev_stay) begin
               data_in = new_data;
               prio_in = new_prio;
            end else begin
               data_in = prev_data;
               prio_in = prev_prio;
            end
         end
      end else if (ctrl.del) begin
         data_in = next_data;
         prio_in = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

endmodule

### rtl/core/spaq_csr.sv
// ----------------------------------------------------------------------------
// spaq_csr
// Register port: holds the capacity limit and answers reads.
// ----------------------------------------------------------------------------
module spaq_csr
   import spaq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CAP_W-1:0]      capacity
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             wr_en;
   logic             reg_index;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign capacity   = capacity_ff;

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_CAPACITY: capacity_in = csr_pwdata[CAP_W-1:0];
            default:      capacity_in = capacity_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(capacity_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

### rtl/core/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Latency: a result is valid the cycle after its request transfer.
// Throughput: one insert or delete per cycle unless stalled; cells shift,
// load or hold that cycle; the single result register refills as it drains.
// Reset: count, result valid and capacity (to 16) clear at once; stored
// entries are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_macros.svh"

module sorted_array_priority_queue
   import spaq_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   logic [CAP_W-1:0]         capacity;
   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;
   logic                     req_xfer;
   logic                     full;
   logic                     do_ins, do_del;
   cell_ctrl_type            ctrl;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic                     front_ok;

   logic [DATA_W-1:0]        cell_data [DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
   logic                     cell_stay [DEPTH];

   spaq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign new_prio  = PRIORITY_BITS'(req_payload.item_priority);

   // limit is the smaller of capacity and depth
   assign full   = (LW'(count_ff) >= LW'(capacity)) || (count_ff == CW'(DEPTH));
   assign do_ins = req_xfer && (req_payload.req_type == OP_INSERT) && !full;
   assign do_del = req_xfer && (req_payload.req_type == OP_DELETE) && (count_ff != '0);

   assign ctrl.ins = do_ins;
   assign ctrl.del = do_del;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0]        prev_data, next_data;
      logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
      logic                     prev_stay;

      if (i == 0) begin : g_head
         assign prev_data = req_payload.item_data;
         assign prev_prio = new_prio;
         assign prev_stay = 1'b1;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
         assign prev_prio = cell_prio[i-1];
         assign prev_stay = cell_stay[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
         assign next_prio = cell_prio[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
         assign next_prio = cell_prio[i+1];
      end

      spaq_cell #(
         .PRIO_BITS (PRIORITY_BITS),
         .CNT_BITS  (CW),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .new_data  (req_payload.item_data),
         .new_prio  (new_prio),
         .prev_data (prev_data),
         .prev_prio (prev_prio),
         .prev_stay (prev_stay),
         .next_data (next_data),
         .next_prio (next_prio),
         .data      (cell_data[i]),
         .prio      (cell_prio[i]),
         .stay      (cell_stay[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_payload_in                 = rsp_payload_ff;
      rsp_valid_in                   = rsp_valid_ff && rsp_stall;
      if (req_xfer) begin
         rsp_valid_in                    = 1'b1;
         rsp_payload_in.status           = ST_OK;
         rsp_payload_in.popped_data      = '0;
         rsp_payload_in.popped_priority  = '0;
         rsp_payload_in.entry_count      = COUNT_W'(count_in);
         if (req_payload.req_type == OP_INSERT) begin
            if (full) begin
               rsp_payload_in.status = ST_FULL;
            end
         end else if (count_ff == '0) begin
            rsp_payload_in.status = ST_EMPTY;
         end else begin
            rsp_payload_in.popped_data     = cell_data[0];
            rsp_payload_in.popped_priority = FIELD_PRIO'(cell_prio[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign front_ok = (count_ff < CW'(2)) || (cell_prio[0] >= cell_prio[1]);

   `SPAQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "count above depth")
   `SPAQ_ASSERT_NEXT(a_ins_count, do_ins, count_ff == $past(count_ff) + CW'(1), "insert lost")
   `SPAQ_ASSERT_ALWAYS(a_front_sorted, front_ok, "front out of order")

endmodule

### test/tb_sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the sorted-array priority queue: a shadow copy of
// the sorted entry array predicts status, popped entry and count for every
// request transfer, across several capacity settings, with random gaps,
// receiver back-pressure and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue
   import spaq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 75;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the queue contents, front at index 0
   logic signed [DATA_W-1:0] shadow_data [DEPTH];
   logic [FIELD_PRIO-1:0]    shadow_prio [DEPTH];
   int                       shadow_count    = 0;
   int                       shadow_capacity = int'(CAPACITY_RESET);

   req_payload_type req_backlog [$];
   rsp_payload_type pending_rsps [$];

   int          idle_pct      = 24;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int unsigned error_count   = 0;

   sorted_array_priority_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_payload_type apply_request(req_payload_type r);
      rsp_payload_type o;
      int              limit;
      int              pos;
      int              k;
      o = '0;
      o.status = ST_OK;
      limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
      if (r.req_type == OP_INSERT) begin
         if (shadow_count >= limit) begin
            o.status = ST_FULL;
         end else begin
            // slide lower-priority entries back, ties keep arrival order
            pos = shadow_count;
            while (pos > 0 && shadow_prio[pos-1] < r.item_priority) begin
               shadow_data[pos] = shadow_data[pos-1];
               shadow_prio[pos] = shadow_prio[pos-1];
               pos--;
            end
            shadow_data[pos] = r.item_data;
            shadow_prio[pos] = r.item_priority;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.popped_data     = shadow_data[0];
            o.popped_priority = shadow_prio[0];
            for (k = 1; k < shadow_count; k++) begin
               shadow_data[k-1] = shadow_data[k];
               shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
         end
      end
      o.entry_count = COUNT_W'(shadow_count);
      return o;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // request driver: a new item only once the previous transfer is done
   always @(posedge clock) begin : req_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         offer = (req_backlog.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
         if (offer) begin
            req_payload <= req_backlog.pop_front();
         end
         req_valid <= offer;
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_rsps.push_back(apply_request(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $error("result transfer with no request outstanding");
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("popped_data", want.popped_data, rsp_payload.popped_data);
               check_field("popped_priority", want.popped_priority,
                           rsp_payload.popped_priority);
               check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            end
         end
      end
   end

   task automatic push_insert(logic signed [DATA_W-1:0] d, logic [FIELD_PRIO-1:0] p);
      req_payload_type r;
      r.req_type      = OP_INSERT;
      r.item_data     = d;
      r.item_priority = p;
      req_backlog.push_back(r);
   endtask

   task automatic push_delete();
      req_payload_type r;
      r.req_type      = OP_DELETE;
      r.item_data     = $urandom;
      r.item_priority = FIELD_PRIO'($urandom);
      req_backlog.push_back(r);
   endtask

   function automatic logic [FIELD_PRIO-1:0] rand_prio();
      case ($urandom_range(0, 3))
         0: begin
            return FIELD_PRIO'($urandom_range(0, 3));
         end
         1: begin
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         default: begin
            return FIELD_PRIO'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // bursts that lean toward filling or toward draining
   task automatic queue_random(int n);
      int left;
      int run;
      int ins_pct;
      left = n;
      while (left > 0) begin
         run     = $urandom_range(4, 24);
         ins_pct = $urandom_range(0, 1) ? 80 : 20;
         if (run > left) begin
            run = left;
         end
         repeat (run) begin
            if ($urandom_range(0, 99) < ins_pct) begin
               push_insert($urandom, rand_prio());
            end else begin
               push_delete();
            end
         end
         left -= run;
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (req_backlog.size() != 0 || req_valid || pending_rsps.size() != 0);
   endtask

   task automatic csr_write(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= ($urandom & ~32'h1f) | CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow_capacity = int'(value);
   endtask

   task automatic run_phase(logic [CAP_W-1:0] cap, int n, int idle, bit hold);
      wait_drained();
      csr_write(cap);
      @(negedge clock);
      idle_pct = idle;
      queue_random(n);
      if (hold) begin
         hold_requests++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extremes and ties at the reset capacity
      @(negedge clock);
      push_delete();
      push_insert(32'sh7fffffff, 8'hff);
      push_insert(32'sh80000000, 8'h00);
      push_insert(-32'sd1, 8'd128);
      push_insert(32'sd0, 8'd128);
      push_insert(32'sd1, 8'hff);
      push_delete();

      // capacity dropped below the count: old entries drain, inserts refused until the count is below it
      wait_drained();
      csr_write(5'd2);
      @(negedge clock);
      push_insert(32'sd9, 8'd7);
      push_delete();
      push_delete();
      push_insert(32'sd9, 8'd7);
      push_delete();
      push_insert(32'sd5, 8'd128);
      push_insert(32'sd6, 8'd200);

      // zero capacity refuses every insert, then delete until empty
      wait_drained();
      csr_write(5'd0);
      @(negedge clock);
      push_insert(32'sd3, 8'd3);
      push_delete();
      push_delete();
      push_delete();

      // capacity above the array depth saturates
      wait_drained();
      csr_write(5'd31);
      @(negedge clock);
      repeat (DEPTH + 1) push_insert($urandom, rand_prio());
      repeat (DEPTH + 1) push_delete();

      run_phase(5'd16, PHASE_ITEMS, 24, 1'b0);
      run_phase(5'd1, PHASE_ITEMS, 0, 1'b0);
      run_phase(5'd31, PHASE_ITEMS, 24, 1'b1);
      run_phase(CAP_W'($urandom_range(2, 15)), PHASE_ITEMS, 24, 1'b0);
      run_phase(5'd4, PHASE_ITEMS, 24, 1'b0);
      run_phase(CAP_W'($urandom_range(0, 31)), PHASE_ITEMS, 24, 1'b0);

      wait_drained();
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_array_priority_queue: match");
      end else begin
         $display("sorted_array_priority_queue: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("sorted_array_priority_queue: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/spaq_pkg.sv
rtl/core/spaq_cell.sv
rtl/core/spaq_csr.sv
rtl/core/sorted_array_priority_queue.sv
test/tb_sorted_array_priority_queue.sv
